// ===== sv/cbe_pkg.sv =====
package cbe_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int NEWTON_STEPS_DEF = 8;
    localparam int BISECT_STEPS_DEF = 32;

    localparam int IN_W  = 18;
    localparam int OUT_W = 19;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_X1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_X2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y2 = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_ADD,
        ST_EVAL,
        ST_DIV_WAIT,
        ST_BIS_CHK,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MD_POS,
        MD_SLOPE,
        MD_BIS,
        MD_Y
    } mode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/cbe_div.sv =====
module cbe_div
    import cbe_pkg::*;
#(
    parameter int NUM_W = 47,
    parameter int DEN_W = 30
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output div_stat_t               stat,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] dmag_reg, dmag_next;
    logic             neg_reg, neg_next;
    logic [DEN_W:0]   rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            q_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_next = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            if (rem_sh >= {1'b0, dmag_reg})
            begin
                rem_next = rem_sh - {1'b0, dmag_reg};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = neg_reg ? NUM_W'(-q_reg) : NUM_W'(q_reg);

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider running with zero count");
`endif

endmodule

// ===== sv/cubic_bezier_easing_core.sv =====
// Channel    Direction  Handshake                Payload
// config     in         cfg_wr_en                cfg_index, cfg_data
// input      in         in_valid / in_ready      progress
// result     out        out_valid / out_ready    eased_value
//
// The identity curve or an endpoint skips the curve arithmetic; otherwise the
// restoring divider (NUM_W = 47 at 16 fraction bits), the bisection steps and the
// shared multiplier, which alternates multiply and add states, set how long an item takes.
// Reset clears the control state and loads the control points to the linear curve.
// in_ready is high only while no item is at work; a result waiting on out_ready
// does not block the next item, which holds in its last state only if the
// output register is still full when it finishes.
module cubic_bezier_easing_core
    import cbe_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
    parameter int BISECT_STEPS = BISECT_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic signed [IN_W-1:0]  cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  progress,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] eased_value
);

    localparam int VW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 13;
    localparam int PW    = 2 * VW;
    localparam int DW    = VW + FRAC_BITS + 1;
    localparam int NC_W  = $clog2(NEWTON_STEPS + 1);
    localparam int BC_W  = $clog2(BISECT_STEPS + 1);

    localparam logic signed [VW-1:0] ONE   = VW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [VW-1:0] SLIM  = VW'(64'sd4 <<< FRAC_BITS);
    localparam logic signed [VW-1:0] OMAX  = VW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] OMIN  = VW'(-(64'sd1 <<< (OUT_W - 1)));
    localparam logic signed [PW-1:0] RND   = PW'((64'sd1 <<< FRAC_BITS) - 64'sd1);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic signed [IN_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;

    logic signed [VW-1:0] t_reg, t_next;
    logic signed [VW-1:0] s_reg, s_next;
    logic signed [VW-1:0] lo_reg, lo_next;
    logic signed [VW-1:0] hi_reg, hi_next;
    logic signed [VW-1:0] acc_reg, acc_next;
    logic signed [VW-1:0] cb_reg, cb_next;
    logic signed [VW-1:0] cc_reg, cc_next;
    logic signed [VW-1:0] err_reg, err_next;
    logic signed [VW-1:0] ax_reg, ax_next, bx_reg, bx_next, cx_reg, cx_next;
    logic signed [VW-1:0] ay_reg, ay_next, by_reg, by_next, cy_reg, cy_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [VW-1:0] res_reg, res_next;
    logic [1:0]           step_reg, step_next;
    logic [1:0]           last_reg, last_next;
    logic [NC_W-1:0]      ncnt_reg, ncnt_next;
    logic [BC_W-1:0]      bcnt_reg, bcnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_reg, out_next;

    logic signed [VW-1:0] prog_ext, x1c, x2c, y1e, y2e;
    logic signed [VW-1:0] fm, addend;
    logic signed [PW-1:0] prod_adj;
    logic                 trivial, hit, div_start;
    logic signed [DW-1:0] dividend, quot;
    logic signed [DW:0]   s_diff;
    logic signed [VW-1:0] s_clamped;
    logic signed [VW:0]   mid_sum;
    div_stat_t            div_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            y1_reg <= '0;
            x2_reg <= IN_W'(ONE);
            y2_reg <= IN_W'(ONE);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_X1:  x1_reg <= cfg_data;
                REG_Y1:  y1_reg <= cfg_data;
                REG_X2:  x2_reg <= cfg_data;
                REG_Y2:  y2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prog_ext = VW'(progress);
        x1c = VW'(x1_reg);
        x2c = VW'(x2_reg);
        y1e = VW'(y1_reg);
        y2e = VW'(y2_reg);
        if (x1c < 0)
            x1c = '0;
        else if (x1c > ONE)
            x1c = ONE;
        if (x2c < 0)
            x2c = '0;
        else if (x2c > ONE)
            x2c = ONE;
        trivial = (x1c == y1e && x2c == y2e) || t_reg <= 0 || t_reg >= ONE;
        hit     = (acc_reg == t_reg);

        prod_adj = prod_reg + (prod_reg[PW-1] ? RND : '0);
        fm       = VW'(prod_adj >>> FRAC_BITS);
        case (step_reg)
            2'd0:    addend = cb_reg;
            2'd1:    addend = cc_reg;
            default: addend = '0;
        endcase

        dividend  = DW'(err_reg) <<< FRAC_BITS;
        s_diff    = (DW+1)'(s_reg) - (DW+1)'(quot);
        if (s_diff > (DW+1)'(SLIM))
            s_clamped = SLIM;
        else if (s_diff < -(DW+1)'(SLIM))
            s_clamped = -SLIM;
        else
            s_clamped = VW'(s_diff);

        mid_sum = (acc_reg > t_reg) ? ((VW+1)'(lo_reg) + (VW+1)'(s_reg))
                                    : ((VW+1)'(s_reg) + (VW+1)'(hi_reg));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PREP;
            ST_PREP:
                state_next = trivial ? ST_FIN : ST_MUL;
            ST_MUL:
                state_next = ST_ADD;
            ST_ADD:
                state_next = (step_reg == last_reg) ? ST_EVAL : ST_MUL;
            ST_EVAL:
            begin
                unique case (mode_reg)
                    MD_POS:   state_next = ST_MUL;
                    MD_SLOPE: state_next = (acc_reg == '0) ? ST_BIS_CHK : ST_DIV_WAIT;
                    MD_BIS:   state_next = hit ? ST_MUL : ST_BIS_CHK;
                    MD_Y:     state_next = ST_FIN;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_DIV_WAIT:
                if (div_stat.done)
                    state_next = (ncnt_reg == NC_W'(NEWTON_STEPS - 1)) ? ST_BIS_CHK : ST_MUL;
            ST_BIS_CHK:
                state_next = ST_MUL;
            ST_FIN:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next = mode_reg;
        t_next = t_reg;
        s_next = s_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        acc_next = acc_reg;
        cb_next = cb_reg;
        cc_next = cc_reg;
        err_next = err_reg;
        ax_next = ax_reg;
        bx_next = bx_reg;
        cx_next = cx_reg;
        ay_next = ay_reg;
        by_next = by_reg;
        cy_next = cy_reg;
        prod_next = prod_reg;
        res_next = res_reg;
        step_next = step_reg;
        last_next = last_reg;
        ncnt_next = ncnt_reg;
        bcnt_next = bcnt_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        div_start = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (prog_ext < 0)
                        t_next = '0;
                    else if (prog_ext > ONE)
                        t_next = ONE;
                    else
                        t_next = prog_ext;
                end
            ST_PREP:
            begin
                ax_next = ONE + (x1c + (x1c <<< 1)) - (x2c + (x2c <<< 1));
                bx_next = (x2c + (x2c <<< 1)) - ((x1c <<< 2) + (x1c <<< 1));
                cx_next = x1c + (x1c <<< 1);
                ay_next = ONE + (y1e + (y1e <<< 1)) - (y2e + (y2e <<< 1));
                by_next = (y2e + (y2e <<< 1)) - ((y1e <<< 2) + (y1e <<< 1));
                cy_next = y1e + (y1e <<< 1);
                res_next = t_reg;
                s_next = t_reg;
                ncnt_next = '0;
                acc_next = ONE + (x1c + (x1c <<< 1)) - (x2c + (x2c <<< 1));
                cb_next = (x2c + (x2c <<< 1)) - ((x1c <<< 2) + (x1c <<< 1));
                cc_next = x1c + (x1c <<< 1);
                last_next = 2'd2;
                step_next = '0;
                mode_next = MD_POS;
            end
            ST_MUL:
                prod_next = PW'(acc_reg) * PW'(s_reg);
            ST_ADD:
            begin
                acc_next = fm + addend;
                step_next = step_reg + 2'd1;
            end
            ST_EVAL:
            begin
                step_next = '0;
                unique case (mode_reg)
                    MD_POS:
                        if (hit)
                        begin
                            acc_next = ay_reg;
                            cb_next = by_reg;
                            cc_next = cy_reg;
                            last_next = 2'd2;
                            mode_next = MD_Y;
                        end
                        else
                        begin
                            err_next = acc_reg - t_reg;
                            acc_next = ax_reg + (ax_reg <<< 1);
                            cb_next = bx_reg <<< 1;
                            cc_next = cx_reg;
                            last_next = 2'd1;
                            mode_next = MD_SLOPE;
                        end
                    MD_SLOPE:
                        if (acc_reg == '0)
                        begin
                            lo_next = '0;
                            hi_next = ONE;
                            s_next = t_reg;
                            bcnt_next = '0;
                        end
                        else
                            div_start = 1'b1;
                    MD_BIS:
                        if (hit)
                        begin
                            acc_next = ay_reg;
                            cb_next = by_reg;
                            cc_next = cy_reg;
                            last_next = 2'd2;
                            mode_next = MD_Y;
                        end
                        else
                        begin
                            if (acc_reg > t_reg)
                                hi_next = s_reg;
                            else
                                lo_next = s_reg;
                            s_next = VW'(mid_sum >>> 1);
                            bcnt_next = bcnt_reg + BC_W'(1);
                        end
                    MD_Y:
                        if (acc_reg > OMAX)
                            res_next = OMAX;
                        else if (acc_reg < OMIN)
                            res_next = OMIN;
                        else
                            res_next = acc_reg;
                    default: ;
                endcase
            end
            ST_DIV_WAIT:
                if (div_stat.done)
                begin
                    step_next = '0;
                    if (ncnt_reg == NC_W'(NEWTON_STEPS - 1))
                    begin
                        lo_next = '0;
                        hi_next = ONE;
                        s_next = t_reg;
                        bcnt_next = '0;
                    end
                    else
                    begin
                        s_next = s_clamped;
                        ncnt_next = ncnt_reg + NC_W'(1);
                        acc_next = ax_reg;
                        cb_next = bx_reg;
                        cc_next = cx_reg;
                        last_next = 2'd2;
                        mode_next = MD_POS;
                    end
                end
            ST_BIS_CHK:
            begin
                step_next = '0;
                last_next = 2'd2;
                if (bcnt_reg == BC_W'(BISECT_STEPS))
                begin
                    acc_next = ay_reg;
                    cb_next = by_reg;
                    cc_next = cy_reg;
                    mode_next = MD_Y;
                end
                else
                begin
                    acc_next = ax_reg;
                    cb_next = bx_reg;
                    cc_next = cx_reg;
                    mode_next = MD_BIS;
                end
            end
            ST_FIN:
                if (!out_valid_reg || out_ready)
                begin
                    out_next = OUT_W'(res_reg);
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg <= MD_POS;
            step_reg <= '0;
            last_reg <= '0;
            ncnt_reg <= '0;
            bcnt_reg <= '0;
            out_valid_reg <= 1'b0;
            s_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            step_reg <= step_next;
            last_reg <= last_next;
            ncnt_reg <= ncnt_next;
            bcnt_reg <= bcnt_next;
            out_valid_reg <= out_valid_next;
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        acc_reg <= acc_next;
        cb_reg <= cb_next;
        cc_reg <= cc_next;
        err_reg <= err_next;
        ax_reg <= ax_next;
        bx_reg <= bx_next;
        cx_reg <= cx_next;
        ay_reg <= ay_next;
        by_reg <= by_next;
        cy_reg <= cy_next;
        prod_reg <= prod_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    cbe_div #(
        .NUM_W (DW),
        .DEN_W (VW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dividend),
        .den   (acc_reg),
        .stat  (div_stat),
        .quot  (quot)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign eased_value = out_reg;

`ifndef SYNTH
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_stat.busy)
        else $error("input ready while a division runs");
    a_div_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_WAIT |-> (div_stat.busy || div_stat.done))
        else $error("waiting on a divider that is not running");
    a_bisect_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= BC_W'(BISECT_STEPS))
        else $error("bisection count past its limit");
    a_s_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (s_reg <= SLIM) && (s_reg >= -SLIM))
        else $error("curve parameter outside its saturation range");
`endif

endmodule

// ===== verif/tb_cubic_bezier_easing_core.sv =====
`timescale 1ns / 1ps

module tb_cubic_bezier_easing_core;
    import cbe_pkg::*;

    localparam longint ONE = 64'sd65536;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [IDX_W-1:0]        cfg_index;
    logic signed [IN_W-1:0]  cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [IN_W-1:0]  progress;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] eased_value;

    // control points as the block holds them
    longint pt_x1;
    longint pt_y1;
    longint pt_x2;
    longint pt_y2;

    logic signed [IN_W-1:0]  progress_q[$];
    logic signed [OUT_W-1:0] eased_q[$];
    int  errors;
    bit  took;
    bit  hold_off;
    int  burst_left;
    int  gap_left;

    cubic_bezier_easing_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .progress    (progress),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .eased_value (eased_value)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) / ONE;
    endfunction

    function automatic longint curve_at(longint s, longint p1, longint p2);
        longint a;
        longint b;
        longint c;
        a = ONE + 3 * p1 - 3 * p2;
        b = 3 * p2 - 6 * p1;
        c = 3 * p1;
        return fx_mul(fx_mul(fx_mul(a, s) + b, s) + c, s);
    endfunction

    function automatic longint curve_slope(longint s, longint p1, longint p2);
        longint a;
        longint b;
        longint c;
        a = ONE + 3 * p1 - 3 * p2;
        b = 3 * p2 - 6 * p1;
        c = 3 * p1;
        return fx_mul(fx_mul(3 * a, s) + 2 * b, s) + c;
    endfunction

    function automatic longint find_param(longint x, longint x1, longint x2);
        longint s;
        longint lo;
        longint hi;
        longint err;
        longint slp;
        longint v;
        s = x;
        lo = 0;
        hi = ONE;
        for (int i = 0; i < NEWTON_STEPS_DEF; i++)
        begin
            err = curve_at(s, x1, x2) - x;
            if (err == 0)
                return s;
            slp = curve_slope(s, x1, x2);
            if (slp == 0)
                break;
            s = clip(s - (err * ONE) / slp, -4 * ONE, 4 * ONE);
        end
        // fall back to bisection over the unit interval
        s = x;
        for (int i = 0; i < BISECT_STEPS_DEF; i++)
        begin
            v = curve_at(s, x1, x2);
            if (v == x)
                break;
            if (v > x)
                hi = s;
            else
                lo = s;
            s = (lo + hi) / 2;
        end
        return s;
    endfunction

    function automatic logic signed [OUT_W-1:0] ease_of(logic signed [IN_W-1:0] p);
        longint t;
        longint x1;
        longint x2;
        longint r;
        t = clip(longint'(p), 0, ONE);
        x1 = clip(pt_x1, 0, ONE);
        x2 = clip(pt_x2, 0, ONE);
        if ((x1 == pt_y1 && x2 == pt_y2) || t <= 0 || t >= ONE)
            r = t;
        else
            r = curve_at(find_param(t, x1, x2), pt_y1, pt_y2);
        r = clip(r, -262144, 262143);
        return r[OUT_W-1:0];
    endfunction

    // source side: bursts with random gaps, one update per falling edge
    always @(negedge clk)
    begin
        logic                   nv;
        logic signed [IN_W-1:0] nd;
        nv = in_valid;
        nd = progress;
        if (rst_n && !(in_valid && !took))
        begin
            took = 1'b0;
            nv = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (!hold_off && progress_q.size() > 0)
            begin
                nd = progress_q.pop_front();
                nv = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        in_valid <= nv;
        progress <= nd;
    end

    // sink side: switch between always ready, light and heavy stalls
    always @(negedge clk)
    begin
        int rdy_mode;
        int rdy_cnt;
        if (rdy_cnt == 0)
        begin
            rdy_mode = $urandom_range(0, 2);
            rdy_cnt = $urandom_range(20, 300);
        end
        rdy_cnt--;
        case (rdy_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        logic signed [OUT_W-1:0] want;
        if (in_valid && in_ready)
        begin
            eased_q.push_back(ease_of(progress));
            took = 1'b1;
        end
        if (out_valid && out_ready)
        begin
            if (eased_q.size() == 0)
            begin
                $error("eased_value: no result expected, got %0d", eased_value);
                errors++;
            end
            else
            begin
                want = eased_q.pop_front();
                if (eased_value !== want)
                begin
                    $error("eased_value: expected %0d, got %0d", want, eased_value);
                    errors++;
                end
            end
        end
    end

    // check at the rising edge, where the source queue and in_valid agree
    task automatic wait_idle();
        do
            @(posedge clk);
        while (progress_q.size() != 0 || in_valid || eased_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic signed [IN_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_X1: pt_x1 = longint'(val);
            REG_Y1: pt_y1 = longint'(val);
            REG_X2: pt_x2 = longint'(val);
            REG_Y2: pt_y2 = longint'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_curve(int x1, int y1, int x2, int y2);
        wait_idle();
        write_reg(REG_X1, IN_W'(x1));
        write_reg(REG_Y1, IN_W'(y1));
        write_reg(REG_X2, IN_W'(x2));
        write_reg(REG_Y2, IN_W'(y2));
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                progress_q.push_back(IN_W'($urandom()));
            else
                progress_q.push_back(IN_W'($urandom_range(0, 65536)));
        end
    endtask

    task automatic add_directed();
        progress_q.push_back(-18'sd131072);
        progress_q.push_back(18'sd131071);
        progress_q.push_back(-18'sd1);
        progress_q.push_back(18'sd0);
        progress_q.push_back(18'sd1);
        progress_q.push_back(18'sd32768);
        progress_q.push_back(18'sd65535);
        progress_q.push_back(18'sd65536);
        progress_q.push_back(18'sd65537);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        progress = '0;
        out_ready = 1'b0;
        errors = 0;
        took = 1'b0;
        hold_off = 1'b0;
        burst_left = 0;
        gap_left = 0;
        pt_x1 = 0;
        pt_y1 = 0;
        pt_x2 = ONE;
        pt_y2 = ONE;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // linear curve out of reset: identity path
        add_directed();
        add_random(40);
        // standard ease
        set_curve(16384, 6554, 16384, 65536);
        add_directed();
        add_random(120);
        // hold the source until the block drains, then resume
        hold_off = 1'b1;
        do
            @(posedge clk);
        while (eased_q.size() != 0 || in_valid);
        hold_off = 1'b0;
        add_random(60);
        // extremes of every register, overshooting y
        set_curve(-131072, 131071, 131071, -131072);
        add_directed();
        add_random(100);
        set_curve(131071, -131072, -131072, 131071);
        add_directed();
        add_random(100);
        // flat start: zero slope at the origin
        set_curve(0, 0, 65536, 65536);
        write_reg(REG_Y1, 30000);
        add_random(80);
        // steep middle section with both x at one
        set_curve(65536, 0, 65536, 65536);
        add_random(80);
        // writes beyond the last register must not land
        wait_idle();
        for (int i = 4; i < 8; i++)
            write_reg(IDX_W'(i), IN_W'($urandom()));
        add_random(60);
        for (int k = 0; k < 5; k++)
        begin
            set_curve($urandom(), $urandom(), $urandom(), $urandom());
            add_random(90);
        end
        // out-of-range x points that clamp to the identity curve
        set_curve(-500, 0, 70000, 65536);
        add_random(40);

        wait_idle();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #80ms;
        $display("status: fail");
        $finish;
    end

endmodule
